[rtl/core/tme_pkg.sv]
// Shared types and fixed sizes for the twist matrix exponential block.
package tme_pkg;

    localparam int DATA_W  = 32;
    localparam int N_IN    = 7;
    localparam int N_OUT   = 12;
    localparam int IN_W    = DATA_W * N_IN;
    localparam int OUT_W   = DATA_W * N_OUT;
    // A 33 by 32 bit product and a sum of up to three of them, with margin.
    localparam int PROD_W  = 65;
    localparam int ACC_W   = 67;
    // Quotient bits produced by the divider before the result is known to saturate.
    localparam int QUO_W   = 33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRN,
        S_TRN_RND,
        S_AMUL,
        S_AWR,
        S_TMAC,
        S_TRND,
        S_TDIV,
        S_TUPD,
        S_OUT
    } state_t;

endpackage

[rtl/core/twist_matrix_exponential.sv]
// Top level: twist matrix exponential by truncated Taylor series, memory based.

// One beat on s_* carries an axis, a point on the axis and an angle; one beat on m_*
// returns the top three rows of the pose exp(twist*angle), all in signed fixed point with
// FRAC_BITS fraction bits and saturated. Items are worked on one at a time. An item works
// through n series terms, n being term_count limited to MAX_TERMS: each of the twelve
// entries of every series term takes three multiply steps on the one shared multiplier and
// a bit-serial divider for the division by the term index. A finished pose waits in the
// output register while the next beat is taken. term_count (reset 10) is to be written
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module twist_matrix_exponential
    import tme_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // omega_x, omega_y, omega_z, point_x, point_y, point_z, angle
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rot_00, rot_01, rot_02, shift_x, rot_10, rot_11, rot_12, shift_y,
    // rot_20, rot_21, rot_22, shift_z
    output logic [OUT_W-1:0] m_tdata
);

    localparam int J_W = $clog2(MAX_TERMS + 1);
    localparam int D_W = J_W + 1;
    localparam int NUM_W = ACC_W + 2;
    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-DATA_W){1'b0}}, S_MAX};
        lo = {{(ACC_W-DATA_W){1'b1}}, S_MIN};
        if (v > hi)
            return S_MAX;
        else if (v < lo)
            return S_MIN;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
        if (v == S_MIN)
            return S_MAX;
        else
            return -v;
    endfunction

    state_t state_reg, state_next;
    logic [1:0]       r_reg, r_next, c_reg, c_next, k_reg, k_next, ph_reg, ph_next;
    logic [J_W-1:0]   j_reg, j_next;
    logic             bank_reg, bank_next;
    logic [5:0]       dcnt_reg, dcnt_next;
    logic [3:0]       oe_reg, oe_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [4:0]       term_count_reg;
    logic [J_W-1:0]   n_eff;

    logic signed [DATA_W-1:0] in_reg [N_IN];
    logic signed [DATA_W-1:0] tw3_reg [3];
    logic signed [DATA_W-1:0] out_reg [N_OUT];

    logic signed [DATA_W:0]   mul_x;
    logic signed [DATA_W-1:0] mul_y;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [DATA_W-1:0] tw_sel;

    logic signed [DATA_W-1:0] mem_a [16];
    logic signed [DATA_W-1:0] mem_t [32];
    logic signed [DATA_W-1:0] mem_p [16];
    logic signed [DATA_W-1:0] a_rd_reg, t_rd_reg, p_rd_reg;
    logic [3:0] a_raddr, p_raddr;
    logic [4:0] t_raddr;

    logic             sign_reg, big_reg;
    logic [D_W-1:0]   rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [D_W-1:0]   divisor;
    logic [D_W:0]     trial;
    logic             trial_ge;
    logic [ACC_W-1:0] mag;
    logic [NUM_W-1:0] num;
    logic signed [DATA_W-1:0] nt;
    logic signed [DATA_W:0]   p_sum;
    logic signed [DATA_W-1:0] p_new;
    logic             last_entry;
    logic [DATA_W-1:0] ident;

    assign n_eff = (32'(term_count_reg) > MAX_TERMS) ? J_W'(MAX_TERMS) : J_W'(term_count_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign last_entry = (r_reg == 2'd2) && (c_reg == 2'd3);
    assign ident = (r_reg == c_reg) ? ONE_FX : '0;

    always_comb
    begin
        for (int i = 0; i < N_OUT; i++)
        begin
            m_tdata[i*DATA_W +: DATA_W] = out_reg[i];
        end
    end

    // Skew part of the twist, or the translation column once it is known.
    always_comb
    begin
        tw_sel = '0;
        unique case ({r_reg, c_reg})
            4'h1:    tw_sel = neg_sat(in_reg[2]);
            4'h2:    tw_sel = in_reg[1];
            4'h4:    tw_sel = in_reg[2];
            4'h6:    tw_sel = neg_sat(in_reg[0]);
            4'h8:    tw_sel = neg_sat(in_reg[1]);
            4'h9:    tw_sel = in_reg[0];
            4'h3, 4'h7, 4'hB: tw_sel = tw3_reg[r_reg];
            default: tw_sel = '0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        priority case (state_reg)
            S_TRN:
            begin
                unique case ({r_reg, k_reg[0]})
                    3'b000:  begin mul_x = {in_reg[2][DATA_W-1], in_reg[2]}; mul_y = in_reg[4]; end
                    3'b001:  begin mul_x = -{in_reg[1][DATA_W-1], in_reg[1]}; mul_y = in_reg[5]; end
                    3'b010:  begin mul_x = {in_reg[0][DATA_W-1], in_reg[0]}; mul_y = in_reg[5]; end
                    3'b011:  begin mul_x = -{in_reg[2][DATA_W-1], in_reg[2]}; mul_y = in_reg[3]; end
                    3'b100:  begin mul_x = {in_reg[1][DATA_W-1], in_reg[1]}; mul_y = in_reg[3]; end
                    3'b101:  begin mul_x = -{in_reg[0][DATA_W-1], in_reg[0]}; mul_y = in_reg[4]; end
                    default: begin mul_x = '0; mul_y = '0; end
                endcase
            end
            S_AMUL:
            begin
                mul_x = {tw_sel[DATA_W-1], tw_sel};
                mul_y = in_reg[6];
            end
            S_TMAC:
            begin
                mul_x = {t_rd_reg[DATA_W-1], t_rd_reg};
                mul_y = a_rd_reg;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign rnd = (acc_reg + HALF) >>> FRAC_BITS;

    // Rounded term entry before the division: sign, magnitude and 2*|v| + j.
    assign divisor = {j_reg, 1'b0};
    assign mag = rnd[ACC_W-1] ? ACC_W'(-rnd) : ACC_W'(rnd);
    assign num = {mag, 1'b0} + NUM_W'(j_reg);
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor});

    always_comb
    begin
        if (big_reg)
            nt = sign_reg ? S_MIN : S_MAX;
        else if (!sign_reg)
            nt = (quo_reg > QUO_W'(S_MAX)) ? S_MAX : quo_reg[DATA_W-1:0];
        else
            nt = (quo_reg > {1'b0, S_MIN}) ? S_MIN : -quo_reg[DATA_W-1:0];
    end

    assign p_sum = {p_rd_reg[DATA_W-1], p_rd_reg} + {nt[DATA_W-1], nt};
    assign p_new = (p_sum[DATA_W] != p_sum[DATA_W-1]) ? (p_sum[DATA_W] ? S_MIN : S_MAX)
                                                       : p_sum[DATA_W-1:0];

    assign t_raddr = {bank_reg, r_reg, k_reg};
    assign a_raddr = {k_reg, c_reg};
    assign p_raddr = (state_reg == S_OUT) ? oe_reg : {r_reg, c_reg};

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        ph_next = ph_reg;
        j_next = j_reg;
        bank_next = bank_reg;
        dcnt_next = dcnt_reg;
        oe_next = oe_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_TRN;
                    r_next = '0;
                    k_next = '0;
                    ph_next = '0;
                end
            end
            S_TRN:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    ph_next = 2'd0;
                    if (k_reg == 2'd1)
                    begin
                        k_next = '0;
                        state_next = S_TRN_RND;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            S_TRN_RND:
            begin
                if (r_reg == 2'd2)
                begin
                    r_next = '0;
                    c_next = '0;
                    state_next = S_AMUL;
                end
                else
                begin
                    r_next = r_reg + 2'd1;
                    state_next = S_TRN;
                end
            end
            S_AMUL:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    ph_next = 2'd0;
                    state_next = S_AWR;
                end
            end
            S_AWR:
            begin
                if (last_entry)
                begin
                    r_next = '0;
                    c_next = '0;
                    k_next = '0;
                    j_next = J_W'(1);
                    bank_next = 1'b0;
                    oe_next = '0;
                    state_next = (n_eff == '0) ? S_OUT : S_TMAC;
                end
                else
                begin
                    if (c_reg == 2'd3)
                    begin
                        c_next = '0;
                        r_next = r_reg + 2'd1;
                    end
                    else
                        c_next = c_reg + 2'd1;
                    state_next = S_AMUL;
                end
            end
            S_TMAC:
            begin
                if (ph_reg != 2'd2)
                    ph_next = ph_reg + 2'd1;
                else
                begin
                    ph_next = 2'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next = '0;
                        state_next = S_TRND;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            S_TRND:
            begin
                dcnt_next = '0;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (dcnt_reg == 6'(QUO_W - 1))
                    state_next = S_TUPD;
                else
                    dcnt_next = dcnt_reg + 6'd1;
            end
            S_TUPD:
            begin
                if (last_entry)
                begin
                    r_next = '0;
                    c_next = '0;
                    bank_next = !bank_reg;
                    if (j_reg == n_eff)
                    begin
                        oe_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        j_next = j_reg + J_W'(1);
                        state_next = S_TMAC;
                    end
                end
                else
                begin
                    if (c_reg == 2'd3)
                    begin
                        c_next = '0;
                        r_next = r_reg + 2'd1;
                    end
                    else
                        c_next = c_reg + 2'd1;
                    state_next = S_TMAC;
                end
            end
            S_OUT:
            begin
                if (oe_reg == 4'd0)
                begin
                    if (!m_tvalid_reg)
                        oe_next = 4'd1;
                end
                else if (oe_reg == 4'(N_OUT))
                begin
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    oe_next = oe_reg + 4'd1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
            ph_reg <= '0;
            j_reg <= '0;
            bank_reg <= 1'b0;
            dcnt_reg <= '0;
            oe_reg <= '0;
            m_tvalid_reg <= 1'b0;
            term_count_reg <= 5'd10;
        end
        else
        begin
            state_reg <= state_next;
            r_reg <= r_next;
            c_reg <= c_next;
            k_reg <= k_next;
            ph_reg <= ph_next;
            j_reg <= j_next;
            bank_reg <= bank_next;
            dcnt_reg <= dcnt_next;
            oe_reg <= oe_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                term_count_reg <= cfg_wdata;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
        if (s_tvalid && s_tready)
        begin
            for (int i = 0; i < N_IN; i++)
            begin
                in_reg[i] <= s_tdata[i*DATA_W +: DATA_W];
            end
        end
        if (((state_reg == S_TRN) || (state_reg == S_AMUL)) && (ph_reg == 2'd1))
            acc_reg <= ((k_reg == 2'd0) ? '0 : acc_reg) + ACC_W'(prod_reg);
        if ((state_reg == S_TMAC) && (ph_reg == 2'd2))
            acc_reg <= ((k_reg == 2'd0) ? '0 : acc_reg) + ACC_W'(prod_reg);
        if (state_reg == S_TRN_RND)
            tw3_reg[r_reg] <= sat_acc(rnd);
        if (state_reg == S_TRND)
        begin
            sign_reg <= rnd[ACC_W-1];
            big_reg <= (num >= (NUM_W'(divisor) << QUO_W));
            rem_reg <= num[QUO_W +: D_W];
            quo_reg <= num[QUO_W-1:0];
        end
        // Restoring division: quotient bits shift in from the bottom as dividend bits leave.
        if (state_reg == S_TDIV)
        begin
            rem_reg <= trial_ge ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if ((state_reg == S_OUT) && (oe_reg != 4'd0))
            out_reg[oe_reg - 4'd1] <= p_rd_reg;
    end

    // Coefficient, term and sum memories. The term memory is double banked so a new term
    // never overwrites entries of the previous one still to be read; each sum entry is
    // read well before the single write back to it, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        a_rd_reg <= mem_a[a_raddr];
        t_rd_reg <= mem_t[t_raddr];
        p_rd_reg <= mem_p[p_raddr];
        if (state_reg == S_AWR)
        begin
            mem_a[{r_reg, c_reg}] <= sat_acc(rnd);
            mem_t[{1'b0, r_reg, c_reg}] <= ident;
            mem_p[{r_reg, c_reg}] <= ident;
        end
        if (state_reg == S_TUPD)
        begin
            mem_t[{!bank_reg, r_reg, c_reg}] <= nt;
            mem_p[{r_reg, c_reg}] <= p_new;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output gather");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_TRN)
        else $error("accepted beat did not start the twist computation");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TDIV) |-> (dcnt_reg < 6'(QUO_W)))
        else $error("divider ran past its quotient width");
`endif

endmodule
